[rtl/hv_timer_irq_nmi_unit_defines.svh]
// Assertion macros used by the checker file of the timer/interrupt unit.
`ifndef HV_TIMER_IRQ_NMI_UNIT_DEFINES_SVH
`define HV_TIMER_IRQ_NMI_UNIT_DEFINES_SVH

// Concurrent check on clk_i, muted while reset is asserted.
`define HVTI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define HVTI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/hvti_pkg.sv]
// Types and constants of the video-timed timer IRQ / vblank NMI unit.
`default_nettype none

package hvti_pkg;

  localparam int unsigned TargetW = 9;
  localparam int unsigned ClockW  = 11;
  localparam int unsigned LineW   = 9;
  localparam int unsigned CfgIdxW = 3;

  // Request kinds
  typedef enum logic [1:0] {
    OP_TIME_ADVANCE = 2'd0,
    OP_LINE_START   = 2'd1,
    OP_LAST_CYCLE   = 2'd2
  } op_e;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_VIRQ_EN    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HIRQ_EN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LINE_TGT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DOT_TGT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NMI_EN     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_JOY_POLL   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TALL_FRAME = 3'd6;

  localparam logic [TargetW-1:0] TARGET_RESET = 9'd511;

  // Line numbers, normal and overscan frames
  localparam logic [LineW-1:0] LAST_VISIBLE_SHORT = 9'd224;
  localparam logic [LineW-1:0] LAST_VISIBLE_TALL  = 9'd239;
  localparam logic [LineW-1:0] VBLANK_SHORT       = 9'd225;
  localparam logic [LineW-1:0] VBLANK_TALL        = 9'd240;
  localparam logic [LineW-1:0] POLL_SHORT         = 9'd227;
  localparam logic [LineW-1:0] POLL_TALL          = 9'd242;

  typedef struct packed {
    logic               virq_enable;
    logic               hirq_enable;
    logic [TargetW-1:0] line_target;
    logic [TargetW-1:0] dot_target;
    logic               nmi_enable;
    logic               joypad_poll_enable;
    logic               tall_frame;
  } cfg_t;

  typedef struct packed {
    logic timer_match;
    logic timer_line;
    logic irq_edge;
    logic vblank_match;
    logic vblank_level;
    logic nmi_edge;
    logic irq_waiting;
    logic nmi_waiting;
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ClockW-1:0] clock_pos;
    logic [LineW-1:0]  line_pos;
    logic [ClockW-1:0] clock_count;
    logic              irq_mask;
  } item_t;

  typedef struct packed {
    logic timer_irq_line;
    logic irq_pending_out;
    logic vblank_line;
    logic nmi_pending_out;
    logic wake;
    logic hdma_init_req;
    logic hdma_run_req;
    logic refresh_req;
    logic joypad_poll_req;
  } result_t;

endpackage

`default_nettype wire

[rtl/hvti_step.sv]
// Next-state and result logic for one request of the interrupt unit.
`default_nettype none

module hvti_step import hvti_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [ClockW-1:0] goal;
  logic [ClockW:0]   reach;
  logic              h_hit;
  logic              v_hit;
  logic [LineW-1:0]  last_visible;
  logic [LineW-1:0]  vblank_start;
  logic [LineW-1:0]  poll_line;
  state_t            ns;
  logic              wake;
  logic              hinit;
  logic              hrun;
  logic              refresh;
  logic              poll;

  // dot target is shifted left by two bits into clock units
  assign goal  = {cfg_i.dot_target, 2'b00};
  assign reach = {1'b0, item_i.clock_pos} + {1'b0, item_i.clock_count};
  assign h_hit = (item_i.clock_pos <= goal) && (reach > {1'b0, goal});
  assign v_hit = (item_i.line_pos == cfg_i.line_target);

  assign last_visible = cfg_i.tall_frame ? LAST_VISIBLE_TALL : LAST_VISIBLE_SHORT;
  assign vblank_start = cfg_i.tall_frame ? VBLANK_TALL : VBLANK_SHORT;
  assign poll_line    = cfg_i.tall_frame ? POLL_TALL : POLL_SHORT;

  always_comb begin
    ns      = state_i;
    wake    = 1'b0;
    hinit   = 1'b0;
    hrun    = 1'b0;
    refresh = 1'b0;
    poll    = 1'b0;
    case (op_e'(item_i.operation))
      OP_TIME_ADVANCE: begin
        // held line keeps re-raising the edge
        if (state_i.timer_line && (cfg_i.virq_enable || cfg_i.hirq_enable)) begin
          ns.irq_edge = 1'b1;
        end
        if (cfg_i.virq_enable && !cfg_i.hirq_enable) begin
          ns.timer_match = v_hit;
        end else if (cfg_i.hirq_enable) begin
          ns.timer_match = h_hit && (!cfg_i.virq_enable || v_hit);
        end
        if (!state_i.timer_match && ns.timer_match) begin
          ns.timer_line = 1'b1;
          ns.irq_edge   = 1'b1;
        end
      end
      OP_LINE_START: begin
        hinit           = (item_i.line_pos == '0);
        refresh         = 1'b1;
        hrun            = (item_i.line_pos <= last_visible);
        ns.vblank_match = (item_i.line_pos >= vblank_start);
        if (!state_i.vblank_match && ns.vblank_match) begin
          ns.vblank_level = 1'b1;
          if (cfg_i.nmi_enable) begin
            ns.nmi_edge = 1'b1;
          end
        end else if (state_i.vblank_match && !ns.vblank_match) begin
          ns.vblank_level = 1'b0;
        end
        poll = cfg_i.joypad_poll_enable && (item_i.line_pos == poll_line);
      end
      OP_LAST_CYCLE: begin
        if (state_i.nmi_edge) begin
          wake           = 1'b1;
          ns.nmi_edge    = 1'b0;
          ns.nmi_waiting = 1'b1;
        end
        if (state_i.irq_edge) begin
          wake           = 1'b1;
          ns.irq_edge    = 1'b0;
          ns.irq_waiting = !item_i.irq_mask;
        end
      end
      default: begin
        // unused code: no change, levels only
      end
    endcase
  end

  assign state_o = ns;

  always_comb begin
    result_o.timer_irq_line  = ns.timer_line;
    result_o.irq_pending_out = ns.irq_waiting;
    result_o.vblank_line     = ns.vblank_level;
    result_o.nmi_pending_out = ns.nmi_waiting;
    result_o.wake            = wake;
    result_o.hdma_init_req   = hinit;
    result_o.hdma_run_req    = hrun;
    result_o.refresh_req     = refresh;
    result_o.joypad_poll_req = poll;
  end

endmodule

`default_nettype wire

[rtl/hv_timer_irq_nmi_unit.sv]
// Top level of the video-timed timer IRQ and vblank NMI unit.
// Each request is one of: a time advance (dot/line counters and a clock
// count, checked against the H/V targets to raise the timer IRQ line on a
// rising match), a scanline start (vblank NMI line plus the per-line
// refresh, HDMA-init, HDMA-run and joypad-poll flags), or an instruction's
// last cycle (pending NMI/IRQ update, IRQ masked by the I flag, WAI wake).
// Every request gives exactly one result. The datapath is two registers
// deep: a request register, then a result register; the step logic between
// them updates the interrupt state as the request moves into the result
// register. Throughput is one request per clock while out_stall_i is low.
// An accepted request goes into the request register, then into the result
// register, and out_valid_o rises once it sits in the result register.
// While a result waits under out_stall_i, one more request is still taken
// into the request register; in_stall_o rises only with both registers full.
// The timer line is never dropped here: acknowledge lives outside this block.
// Configuration registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// and must only change while no request is in flight; indexes past the last
// register are ignored.
`default_nettype none

module hv_timer_irq_nmi_unit import hvti_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TargetW-1:0] cfg_data_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [ClockW-1:0]  clock_pos_i,
  input  wire logic [LineW-1:0]   line_pos_i,
  input  wire logic [ClockW-1:0]  clock_count_i,
  input  wire logic               irq_mask_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    timer_irq_line_o,
  output logic                    irq_pending_out_o,
  output logic                    vblank_line_o,
  output logic                    nmi_pending_out_o,
  output logic                    wake_o,
  output logic                    hdma_init_req_o,
  output logic                    hdma_run_req_o,
  output logic                    refresh_req_o,
  output logic                    joypad_poll_req_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    res_free;
  logic    advance;
  logic    accept;

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.virq_enable        <= 1'b0;
      cfg_q.hirq_enable        <= 1'b0;
      cfg_q.line_target        <= TARGET_RESET;
      cfg_q.dot_target         <= TARGET_RESET;
      cfg_q.nmi_enable         <= 1'b0;
      cfg_q.joypad_poll_enable <= 1'b0;
      cfg_q.tall_frame         <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VIRQ_EN:    cfg_q.virq_enable        <= cfg_data_i[0];
        REG_HIRQ_EN:    cfg_q.hirq_enable        <= cfg_data_i[0];
        REG_LINE_TGT:   cfg_q.line_target        <= cfg_data_i;
        REG_DOT_TGT:    cfg_q.dot_target         <= cfg_data_i;
        REG_NMI_EN:     cfg_q.nmi_enable         <= cfg_data_i[0];
        REG_JOY_POLL:   cfg_q.joypad_poll_enable <= cfg_data_i[0];
        REG_TALL_FRAME: cfg_q.tall_frame         <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // ---- flow control ----
  // result register frees up when empty or being taken this cycle
  assign res_free   = !res_valid_q || !out_stall_i;
  assign advance    = item_valid_q && res_free;
  // request register takes a new one when empty or draining into results
  assign in_stall_o = item_valid_q && !res_free;
  assign accept     = in_valid_i && !in_stall_o;

  // ---- request register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.operation   <= operation_i;
      item_q.clock_pos   <= clock_pos_i;
      item_q.line_pos    <= line_pos_i;
      item_q.clock_count <= clock_count_i;
      item_q.irq_mask    <= irq_mask_i;
    end
  end

  // ---- step logic ----
  hvti_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // interrupt state commits when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign timer_irq_line_o  = res_q.timer_irq_line;
  assign irq_pending_out_o = res_q.irq_pending_out;
  assign vblank_line_o     = res_q.vblank_line;
  assign nmi_pending_out_o = res_q.nmi_pending_out;
  assign wake_o            = res_q.wake;
  assign hdma_init_req_o   = res_q.hdma_init_req;
  assign hdma_run_req_o    = res_q.hdma_run_req;
  assign refresh_req_o     = res_q.refresh_req;
  assign joypad_poll_req_o = res_q.joypad_poll_req;

endmodule

`default_nettype wire

[rtl/hvti_checker.sv]
// Port-level checks of the interrupt unit, bound to its top level.
`default_nettype none

`include "hv_timer_irq_nmi_unit_defines.svh"

module hvti_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic timer_irq_line_o,
  input wire logic wake_o,
  input wire logic hdma_init_req_o,
  input wire logic hdma_run_req_o,
  input wire logic refresh_req_o,
  input wire logic joypad_poll_req_o
);

  // stalled result stays offered
  `HVTI_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // timer line is sticky: once delivered high, later results keep it high
  `HVTI_ASSERT(a_timer_sticky, out_valid_o && !out_stall_i && timer_irq_line_o |=> !out_valid_o || timer_irq_line_o, "timer IRQ line fell")

  // line zero is a visible line start
  `HVTI_ASSERT(a_hinit_line, out_valid_o && hdma_init_req_o |-> refresh_req_o && hdma_run_req_o, "HDMA init without line start")

  // wake only comes from a last-cycle request
  `HVTI_ASSERT(a_wake_excl, out_valid_o && wake_o |-> !refresh_req_o && !joypad_poll_req_o, "wake on a line start")

endmodule

bind hv_timer_irq_nmi_unit hvti_checker u_hvti_checker (.*);

`default_nettype wire
